// ----- sv/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    // Status codes carried on the last result of an input byte
    typedef enum logic [2:0] {
        ST_CONT    = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_CTRL    = 3'd2,
        ST_UNTERM  = 3'd3,
        ST_BADESC  = 3'd4,
        ST_BADHEX  = 3'd5
    } status_t;

    // Work item handed from the decoder front to the output back end
    typedef struct packed {
        logic        fffd;      // U+FFFD goes out before anything else
        logic        emit_en;   // one more character follows
        logic        emit_raw;  // that character is a raw byte, cp[7:0]
        logic [20:0] cp;        // code point to encode
        status_t     status;
    } jsu_rec_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic     avail;
        jsu_rec_t rec;
    } jsu_head_t;

    localparam logic [20:0] CP_REPL    = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP    = 21'h010000;
    localparam logic [5:0]  SURR_HIGH  = 6'b110110;
    localparam logic [5:0]  SURR_LOW   = 6'b110111;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD4      = 8'hF0;
    localparam logic [7:0]  CONT_BYTE  = 8'h80;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;

endpackage

// ----- sv/json_string_unescape_utf8_top.sv -----
// Top level of the JSON string unescaper with UTF-8 output.
//
// Feed the bytes of a JSON string body, one per transfer, starting after the
// opening quote; raise input_end to mark that input ran out. Each input byte
// yields 1 to 6 results: its decoded UTF-8 bytes, then, on a close, an error
// or when no byte came out, a result with byte_valid low and the status.
// The last result of each input carries last. Input is taken one byte per
// cycle while the work queue has room; results leave one per cycle while
// out_ready is high, so the sustained input rate is one byte per cycle for
// bytes with a single result and lower for others, set by the single output
// port. An input byte passes the work queue and then the output register.
// After a close or an error the decoder is ready for a new string.
module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       input_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [2:0] status,
    output logic       last
);

    jsu_rec_t  rec;
    jsu_head_t head;
    logic      full;
    logic      take;
    logic      pop;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .input_end (input_end),
        .rec       (rec)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .wr_rec (rec),
        .full   (full),
        .pop    (pop),
        .head   (head)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .last       (last)
    );

    // A status result closes its input byte's results
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_CONT) |-> last && !byte_valid)
        else $error("status result not marked last");

    // A result without a byte is always the final one and carries zero
    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && (out_byte == 8'd0))
        else $error("byteless result not last or nonzero");

    // Decoded bytes never carry a status
    a_byte_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> (status == ST_CONT))
        else $error("decoded byte with nonzero status");

endmodule

// ----- sv/jsu_front.sv -----
// Decoder front: tracks escape state and turns each input byte into one work item.
module jsu_front
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] in_byte,
    input  logic      input_end,
    output jsu_rec_t  rec
);

    typedef enum logic [5:0] {
        M_PLAIN    = 6'b000001,
        M_ESC      = 6'b000010,
        M_HEX1     = 6'b000100,
        M_PEND     = 6'b001000,
        M_PEND_ESC = 6'b010000,
        M_HEX2     = 6'b100000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  ph_reg, ph_next;

    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] hv;
    logic        esc_hit, esc_u;
    logic [7:0]  esc_char;
    logic        do_plain, do_esc, do_lone;
    status_t     st;

    // Hex digit decode
    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = '0;
        if (in_byte >= "0" && in_byte <= "9")
            hex_d = 4'(in_byte - "0");
        else if (in_byte >= "a" && in_byte <= "f")
            hex_d = 4'(in_byte - "a" + 8'd10);
        else if (in_byte >= "A" && in_byte <= "F")
            hex_d = 4'(in_byte - "A" + 8'd10);
        else
            hex_ok = 1'b0;
    end

    assign hv = {hex_reg[11:0], hex_d};

    // Escape letter map
    always_comb
    begin
        esc_hit  = 1'b1;
        esc_u    = 1'b0;
        esc_char = in_byte;
        case (in_byte)
            "\"", "\\", "/": esc_char = in_byte;
            "b": esc_char = 8'h08;
            "f": esc_char = 8'h0C;
            "n": esc_char = 8'h0A;
            "r": esc_char = 8'h0D;
            "t": esc_char = 8'h09;
            "u":
            begin
                esc_hit = 1'b0;
                esc_u   = 1'b1;
            end
            default: esc_hit = 1'b0;
        endcase
    end

    // Per-byte decode
    always_comb
    begin
        rec       = '0;
        st        = ST_CONT;
        mode_next = mode_reg;
        hex_next  = hex_reg;
        cnt_next  = cnt_reg;
        ph_next   = ph_reg;
        do_plain  = 1'b0;
        do_esc    = 1'b0;
        do_lone   = 1'b0;

        if (input_end)
            st = ST_UNTERM;
        else
        begin
            unique case (mode_reg)
                M_ESC: do_esc = 1'b1;
                M_HEX1:
                begin
                    if (!hex_ok)
                        st = ST_BADHEX;
                    else if (cnt_reg == 2'd3)
                        do_lone = 1'b1;
                    else
                    begin
                        hex_next = hv;
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                M_PEND:
                begin
                    if (in_byte == "\\")
                        mode_next = M_PEND_ESC;
                    else
                    begin
                        rec.fffd = 1'b1;
                        ph_next  = '0;
                        do_plain = 1'b1;
                    end
                end
                M_PEND_ESC:
                begin
                    if (in_byte == "u")
                    begin
                        mode_next = M_HEX2;
                        hex_next  = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        rec.fffd = 1'b1;
                        ph_next  = '0;
                        do_esc   = 1'b1;
                    end
                end
                M_HEX2:
                begin
                    if (!hex_ok)
                    begin
                        rec.fffd = 1'b1;
                        st       = ST_BADHEX;
                    end
                    else if (cnt_reg == 2'd3)
                    begin
                        ph_next = '0;
                        if (hv[15:10] == SURR_LOW)
                        begin
                            hex_next    = '0;
                            cnt_next    = '0;
                            mode_next   = M_PLAIN;
                            rec.emit_en = 1'b1;
                            rec.cp      = CP_SUPP + {1'b0, ph_reg, hv[9:0]};
                        end
                        else
                        begin
                            rec.fffd = 1'b1;
                            do_lone  = 1'b1;
                        end
                    end
                    else
                    begin
                        hex_next = hv;
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                default: do_plain = 1'b1;
            endcase
        end

        // Plain text byte
        if (do_plain)
        begin
            mode_next = M_PLAIN;
            if (in_byte == "\"")
                st = ST_CLOSED;
            else if (in_byte == "\\")
                mode_next = M_ESC;
            else if (in_byte < CTRL_LIMIT)
                st = ST_CTRL;
            else
            begin
                rec.emit_en  = 1'b1;
                rec.emit_raw = 1'b1;
                rec.cp       = {13'd0, in_byte};
            end
        end

        // Letter after a backslash
        if (do_esc)
        begin
            mode_next = M_PLAIN;
            if (esc_u)
            begin
                mode_next = M_HEX1;
                hex_next  = '0;
                cnt_next  = '0;
            end
            else if (esc_hit)
            begin
                rec.emit_en  = 1'b1;
                rec.emit_raw = 1'b1;
                rec.cp       = {13'd0, esc_char};
            end
            else
                st = ST_BADESC;
        end

        // Complete \u value that does not complete a surrogate pair
        if (do_lone)
        begin
            hex_next  = '0;
            cnt_next  = '0;
            mode_next = M_PLAIN;
            if (hv[15:10] == SURR_HIGH)
            begin
                ph_next   = hv[9:0];
                mode_next = M_PEND;
            end
            else if (hv[15:10] == SURR_LOW)
            begin
                rec.emit_en = 1'b1;
                rec.cp      = CP_REPL;
            end
            else
            begin
                rec.emit_en = 1'b1;
                rec.cp      = {5'd0, hv};
            end
        end

        // Close or error returns to the start state
        if (st != ST_CONT)
        begin
            mode_next = M_PLAIN;
            hex_next  = '0;
            cnt_next  = '0;
            ph_next   = '0;
        end
        rec.status = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_PLAIN;
            hex_reg  <= '0;
            cnt_reg  <= '0;
            ph_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cnt_reg  <= cnt_next;
            ph_reg   <= ph_next;
        end
    end

endmodule

// ----- sv/jsu_queue.sv -----
// Short register queue of work items between the front and the back end.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  jsu_rec_t  wr_rec,
    output logic      full,
    input  logic      pop,
    output jsu_head_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jsu_rec_t      mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full       = (cnt_reg == FULL_CNT);
    assign head.avail = (cnt_reg != '0);
    assign head.rec   = mem_reg[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_rec;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + PW'(1);
            if (pop)
                rp_reg <= (rp_reg == LAST_PTR) ? '0 : rp_reg + PW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

// ----- sv/jsu_back.sv -----
// Back end: UTF-8 encodes each work item and sends its results one per transfer.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  jsu_head_t  head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [2:0] status,
    output logic       last
);

    logic [7:0] enc [4];
    logic [7:0] seq [7];
    logic [2:0] enc_len;
    logic [2:0] nb;
    logic [3:0] total;
    logic       need_stat;
    logic [2:0] idx_reg;
    logic       load;
    logic       is_last;
    logic [20:0] cp;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    assign cp = head.rec.cp;

    // UTF-8 encoding of the item's character
    always_comb
    begin
        enc[0] = '0;
        enc[1] = '0;
        enc[2] = '0;
        enc[3] = '0;
        enc_len = '0;
        if (head.rec.emit_en)
        begin
            if (head.rec.emit_raw || cp < 21'h80)
            begin
                enc[0]  = cp[7:0];
                enc_len = 3'd1;
            end
            else if (cp < 21'h800)
            begin
                enc[0]  = LEAD2 | {3'd0, cp[10:6]};
                enc[1]  = CONT_BYTE | {2'd0, cp[5:0]};
                enc_len = 3'd2;
            end
            else if (cp < CP_SUPP)
            begin
                enc[0]  = LEAD3 | {4'd0, cp[15:12]};
                enc[1]  = CONT_BYTE | {2'd0, cp[11:6]};
                enc[2]  = CONT_BYTE | {2'd0, cp[5:0]};
                enc_len = 3'd3;
            end
            else
            begin
                enc[0]  = LEAD4 | {5'd0, cp[20:18]};
                enc[1]  = CONT_BYTE | {2'd0, cp[17:12]};
                enc[2]  = CONT_BYTE | {2'd0, cp[11:6]};
                enc[3]  = CONT_BYTE | {2'd0, cp[5:0]};
                enc_len = 3'd4;
            end
        end
    end

    // Byte sequence: optional replacement character, then the encoding
    always_comb
    begin
        if (head.rec.fffd)
        begin
            seq[0] = 8'hEF;
            seq[1] = 8'hBF;
            seq[2] = 8'hBD;
            seq[3] = enc[0];
            seq[4] = enc[1];
            seq[5] = enc[2];
            seq[6] = enc[3];
            nb     = enc_len + 3'd3;
        end
        else
        begin
            seq[0] = enc[0];
            seq[1] = enc[1];
            seq[2] = enc[2];
            seq[3] = enc[3];
            seq[4] = '0;
            seq[5] = '0;
            seq[6] = '0;
            nb     = enc_len;
        end
        need_stat = (head.rec.status != ST_CONT) || (nb == '0);
        total     = {1'b0, nb} + {3'd0, need_stat};
        is_last   = ({1'b0, idx_reg} == total - 4'd1);
    end

    // Output register advances when empty or taken
    assign load = !out_valid_reg || out_ready;
    assign pop  = load && head.avail && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= head.avail;
            if (head.avail)
                idx_reg <= is_last ? '0 : idx_reg + 3'd1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load && head.avail)
        begin
            if ({1'b0, idx_reg} < nb)
            begin
                out_byte_reg   <= seq[idx_reg];
                byte_valid_reg <= 1'b1;
                status_reg     <= ST_CONT;
            end
            else
            begin
                out_byte_reg   <= '0;
                byte_valid_reg <= 1'b0;
                status_reg     <= head.rec.status;
            end
            last_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule
